// ===== hdl/cbc_pkg.sv =====
`default_nettype none

package cbc_pkg;

  // Default sizes of the body mask store and of the group space.
  localparam int unsigned CBC_MAX_BODIES = 1024;
  localparam int unsigned CBC_MAX_GROUPS = 32;

  // Field widths of the input and result words.
  localparam int unsigned BODY_W  = 10;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned GROUP_W = 5;
  localparam int unsigned INDEX_W = 16;

  // A constraint carries four body fields; a slot selects one of them.
  localparam int unsigned CBC_BODIES_PER_CONSTRAINT = 4;
  localparam int unsigned SLOT_W = 2;

  // Every mask entry carries an epoch tag, so a restart does not need to sweep the store.
  localparam int unsigned EPOCH_W = 4;

  localparam int unsigned BODY_SPAN = 1 << BODY_W;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;      // capture the accepted input word
    logic              rd;        // read the mask of body slot 'slot'
    logic              pick;      // choose the group for the constraint
    logic              wr;        // write the updated mask of body slot 'slot'
    logic              clr;       // write one zero entry of the clearing sweep
    logic              out_load;  // move the result into the output register
    logic [SLOT_W-1:0] slot;
  } cbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [COUNT_W-1:0] count;     // clamped body count of the current constraint
    logic               wrap_req;  // a restart on the input would wrap the epoch
    logic               clr_last;  // the clearing sweep is at its last entry
    logic               skip_wr;   // overflow or no body: no mask is written
    logic               out_free;  // the output register can take a result now
  } cbc_sts_t;

endpackage

`default_nettype wire

// ===== hdl/cbc_if.sv =====
`default_nettype none

interface cbc_in_if;
  import cbc_pkg::*;

  logic               valid;
  logic               ready;
  logic               restart;
  logic [COUNT_W-1:0] body_count;
  logic [BODY_W-1:0]  body_a;
  logic [BODY_W-1:0]  body_b;
  logic [BODY_W-1:0]  body_c;
  logic [BODY_W-1:0]  body_d;

  modport source (
    output valid, restart, body_count, body_a, body_b, body_c, body_d,
    input  ready
  );

  modport sink (
    input  valid, restart, body_count, body_a, body_b, body_c, body_d,
    output ready
  );
endinterface

interface cbc_out_if;
  import cbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [GROUP_W-1:0] group;
  logic               opened_group;
  logic [INDEX_W-1:0] constraint_index;
  logic               overflow;

  modport source (
    output valid, group, opened_group, constraint_index, overflow,
    input  ready
  );

  modport sink (
    input  valid, group, opened_group, constraint_index, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/constraint_batch_coloring.sv =====
// One constraint is processed at a time; a new word is taken only in idle, after the last
// one has moved to the output register. The single-port mask memory takes one read per
// body and, after the group is chosen, one write per body unless the constraint overflows.
// Reset: synchronous, active low; a clearing sweep over all min(MAX_BODIES, 1024) entries
// follows, and the sixteenth restart after each sweep runs another sweep before its
// constraint.
`default_nettype none

module constraint_batch_coloring #(
  parameter int unsigned MAX_BODIES = cbc_pkg::CBC_MAX_BODIES,
  parameter int unsigned MAX_GROUPS = cbc_pkg::CBC_MAX_GROUPS
) (
  input  logic             clk,
  input  logic             rst_n,
  cbc_in_if.sink           in_chan,
  cbc_out_if.source        out_chan
);
  import cbc_pkg::*;

  // The controller sequences one constraint at a time: it reads the mask of every body,
  // lets the datapath pick the lowest group free on all of them (or open a new one), then
  // writes the group bit into each body's mask (not on overflow). The result waits in an
  // output register, so a new word is taken while the previous result is still unclaimed.
  //
  // A restart does not sweep the mask memory. Each entry carries the epoch in which it
  // was written, and a restart advances the epoch, so older entries read as empty. Only
  // when the epoch counter wraps does the controller run a full clearing sweep first.

  cbc_cmd_t cmd;
  cbc_sts_t sts;
  logic     in_ready;

  cbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbc_dp #(
    .MAX_BODIES (MAX_BODIES),
    .MAX_GROUPS (MAX_GROUPS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_restart           (in_chan.restart),
    .in_body_count        (in_chan.body_count),
    .in_body_a            (in_chan.body_a),
    .in_body_b            (in_chan.body_b),
    .in_body_c            (in_chan.body_c),
    .in_body_d            (in_chan.body_d),
    .out_ready            (out_chan.ready),
    .out_valid            (out_chan.valid),
    .out_group            (out_chan.group),
    .out_opened_group     (out_chan.opened_group),
    .out_constraint_index (out_chan.constraint_index),
    .out_overflow         (out_chan.overflow)
  );

  assign in_chan.ready = in_ready;

`ifndef SYNTHESIS
  // An overflowing constraint reports neither a group nor an opened group.
  a_overflow_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.overflow |-> !out_chan.opened_group && out_chan.group == '0)
    else $error("overflow result carries a group");

  // Only one constraint is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_chan.ready)
    else $error("input taken while a constraint is in work");

  // The mask memory has a single port.
  a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && (cmd.wr || cmd.clr)))
    else $error("mask memory read and written in one cycle");
`endif

endmodule

`default_nettype wire

// ===== hdl/cbc_dp.sv =====
`default_nettype none

module cbc_dp #(
  parameter int unsigned MAX_BODIES = cbc_pkg::CBC_MAX_BODIES,
  parameter int unsigned MAX_GROUPS = cbc_pkg::CBC_MAX_GROUPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbc_pkg::cbc_cmd_t             cmd,
  output cbc_pkg::cbc_sts_t             sts,
  input  logic                          in_restart,
  input  logic [cbc_pkg::COUNT_W-1:0]   in_body_count,
  input  logic [cbc_pkg::BODY_W-1:0]    in_body_a,
  input  logic [cbc_pkg::BODY_W-1:0]    in_body_b,
  input  logic [cbc_pkg::BODY_W-1:0]    in_body_c,
  input  logic [cbc_pkg::BODY_W-1:0]    in_body_d,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [cbc_pkg::GROUP_W-1:0]   out_group,
  output logic                          out_opened_group,
  output logic [cbc_pkg::INDEX_W-1:0]   out_constraint_index,
  output logic                          out_overflow
);
  import cbc_pkg::*;

  // Indices beyond the body field range never occur, so the store need not be deeper.
  localparam int unsigned MEM_DEPTH = (MAX_BODIES < BODY_SPAN) ? MAX_BODIES : BODY_SPAN;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned GW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned OPEN_W    = $clog2(MAX_GROUPS + 1);
  localparam int unsigned MEM_W     = MAX_GROUPS + EPOCH_W;
  localparam int unsigned NB        = CBC_BODIES_PER_CONSTRAINT;

  // The body index is reduced modulo the store depth through a rounded-up reciprocal.
  // With the index narrower than the shift and the depth no larger than the index range,
  // the quotient taken from the product is exact.
  localparam int unsigned RECIP_SH  = 2 * BODY_W;
  localparam int unsigned RECIP_W   = RECIP_SH + 1;
  localparam int unsigned RECIP     = ((1 << RECIP_SH) + MEM_DEPTH - 1) / MEM_DEPTH;
  localparam int unsigned PROD_W    = BODY_W + RECIP_W;

  function automatic logic [AW-1:0] wrap_body(input logic [BODY_W-1:0] body);
    logic [PROD_W-1:0]   prod;
    logic [BODY_W-1:0]   quot;
    logic [2*BODY_W:0]   back;
    logic [BODY_W-1:0]   rem;
    prod = PROD_W'(body) * PROD_W'(RECIP);
    quot = prod[RECIP_SH +: BODY_W];
    back = (2*BODY_W+1)'(quot) * (2*BODY_W+1)'(MEM_DEPTH);
    rem  = body - back[BODY_W-1:0];
    return rem[AW-1:0];
  endfunction

  // Mask store: epoch tag on top, group mask below.
  logic [MEM_W-1:0]      mem [MEM_DEPTH];
  logic [MEM_W-1:0]      rdata_r;

  logic [AW-1:0]         addr_r [NB];
  logic [MAX_GROUPS-1:0] old_r  [NB];
  logic [COUNT_W-1:0]    count_r;
  logic [INDEX_W-1:0]    index_r;
  logic [MAX_GROUPS-1:0] used_r;
  logic [GW-1:0]         chosen_r;
  logic                  opened_r;
  logic                  over_r;
  logic [SLOT_W-1:0]     rd_slot_r;

  logic                  rd_pend_r;
  logic [EPOCH_W-1:0]    epoch_r;
  logic [OPEN_W-1:0]     groups_open_r;
  logic [INDEX_W-1:0]    counter_r;
  logic [AW-1:0]         clr_addr_r;
  logic                  out_valid_r;
  logic [GROUP_W-1:0]    out_group_r;
  logic                  out_opened_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic                  out_over_r;

  logic [BODY_W-1:0]     body_in [NB];
  logic [COUNT_W-1:0]    count_in;
  logic [INDEX_W-1:0]    counter_base;
  logic [MAX_GROUPS-1:0] rd_mask;
  logic [MAX_GROUPS-1:0] used_all;
  logic [MAX_GROUPS-1:0] open_mask;
  logic [MAX_GROUPS-1:0] free_mask;
  logic                  found;
  logic [GW-1:0]         sel;
  logic                  can_open;
  logic [GW-1:0]         chosen;
  logic                  opened;
  logic                  over;
  logic [MAX_GROUPS-1:0] pick_bit;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MEM_W-1:0]      mem_wdata;
  logic                  clr_last;

  assign body_in[0] = in_body_a;
  assign body_in[1] = in_body_b;
  assign body_in[2] = in_body_c;
  assign body_in[3] = in_body_d;

  assign count_in = (in_body_count > COUNT_W'(NB)) ? COUNT_W'(NB) : in_body_count;
  assign counter_base = in_restart ? '0 : counter_r;

  // An entry written under an older epoch reads as an empty mask.
  assign rd_mask  = (rdata_r[MEM_W-1 -: EPOCH_W] == epoch_r) ? rdata_r[MAX_GROUPS-1:0] : '0;
  assign used_all = used_r | (rd_pend_r ? rd_mask : '0);

  // First fit: the lowest open group that no body of the constraint uses.
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      open_mask[g] = (OPEN_W'(g) < groups_open_r);
    end
    free_mask = ~used_all & open_mask;
    for (int g = MAX_GROUPS - 1; g >= 0; g--) begin
      if (free_mask[g]) begin
        found = 1'b1;
        sel   = GW'(g);
      end
    end
  end

  assign can_open = (groups_open_r < OPEN_W'(MAX_GROUPS));
  assign chosen   = found ? sel : GW'(groups_open_r);
  assign opened   = !found && can_open;
  assign over     = !found && !can_open;
  assign pick_bit = MAX_GROUPS'(1) << chosen_r;

  assign clr_last  = (clr_addr_r == AW'(MEM_DEPTH - 1));
  assign mem_we    = cmd.wr || cmd.clr;
  assign mem_waddr = cmd.clr ? clr_addr_r : addr_r[cmd.slot];
  assign mem_wdata = cmd.clr ? '0 : {epoch_r, old_r[cmd.slot] | pick_bit};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr_r[cmd.slot]];
    end
  end

  // Payload registers of the constraint in flight.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < NB; k++) begin
        addr_r[k] <= wrap_body(body_in[k]);
      end
      count_r <= count_in;
      index_r <= counter_base;
      used_r  <= '0;
    end else if (rd_pend_r) begin
      used_r <= used_all;
    end
    if (rd_pend_r) begin
      old_r[rd_slot_r] <= rd_mask;
    end
    if (cmd.rd) begin
      rd_slot_r <= cmd.slot;
    end
    if (cmd.pick) begin
      chosen_r <= over ? '0 : chosen;
      opened_r <= opened;
      over_r   <= over;
    end
    if (cmd.out_load) begin
      out_group_r  <= GROUP_W'(chosen_r);
      out_opened_r <= opened_r;
      out_index_r  <= index_r;
      out_over_r   <= over_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r     <= 1'b0;
      epoch_r       <= '0;
      groups_open_r <= '0;
      counter_r     <= '0;
      clr_addr_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      rd_pend_r <= cmd.rd;
      if (cmd.load) begin
        counter_r <= (counter_base == INDEX_MAX) ? counter_base : counter_base + 1'b1;
        if (in_restart) begin
          epoch_r       <= epoch_r + 1'b1;
          groups_open_r <= '0;
        end
      end else if (cmd.pick && opened) begin
        groups_open_r <= groups_open_r + 1'b1;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_last ? '0 : clr_addr_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.count    = count_r;
  assign sts.wrap_req = in_restart && (epoch_r == '1);
  assign sts.clr_last = clr_last;
  assign sts.skip_wr  = over_r || (count_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_group            = out_group_r;
  assign out_opened_group     = out_opened_r;
  assign out_constraint_index = out_index_r;
  assign out_overflow         = out_over_r;

endmodule

`default_nettype wire

// ===== hdl/cbc_ctrl.sv =====
`default_nettype none

module cbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cbc_pkg::cbc_sts_t sts,
  output cbc_pkg::cbc_cmd_t cmd
);
  import cbc_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_PICK   = 6'b001000,
    S_WRITE  = 6'b010000,
    S_FINISH = 6'b100000
  } cbc_state_t;

  cbc_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              pend_r, pend_nxt;
  logic              last_slot;

  assign last_slot = ((COUNT_W'(slot_r) + COUNT_W'(1)) == sts.count);

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    pend_nxt  = pend_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = pend_r ? S_READ : S_IDLE;
          pend_nxt  = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          slot_nxt = '0;
          if (sts.wrap_req) begin
            state_nxt = S_CLEAR;
            pend_nxt  = 1'b1;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (sts.count == '0) begin
          state_nxt = S_PICK;
        end else begin
          cmd.rd   = 1'b1;
          cmd.slot = slot_r;
          if (last_slot) begin
            state_nxt = S_PICK;
            slot_nxt  = '0;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!sts.skip_wr) begin
          cmd.wr   = 1'b1;
          cmd.slot = slot_r;
        end
        if (sts.skip_wr || last_slot) begin
          slot_nxt = '0;
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_FINISH;
          end
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      slot_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

`default_nettype wire
